@@ design/resource_id_range_allocator_macros.svh @@
// Assertion macros used by the allocator sequencer.
`ifndef RESOURCE_ID_RANGE_ALLOCATOR_MACROS_SVH
`define RESOURCE_ID_RANGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define RIDRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked while out of reset.
`define RIDRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ design/ridra_pkg.sv @@
// Types and constants of the ID range allocator.
`default_nettype none
package ridra_pkg;
    localparam int ID_W  = 7;
    localparam int CNT_W = 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARA    = 2'd1;
    localparam logic [1:0] ST_UNAVAIL = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CNT_W-1:0]  count;
        logic              consecutive;
        logic [ID_W-1:0]   start_id;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   piece_start;
        logic [CNT_W-1:0]  piece_count;
        logic              last;
        logic [CNT_W-1:0]  free_count;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [ID_W-1:0]   waddr;
        logic              wdata;
        logic [ID_W-1:0]   raddr;
    } t_ram_req;
endpackage
`default_nettype wire

@@ design/ridra_map_ram.sv @@
// Busy map memory: one write port, one registered read port.
`default_nettype none
module ridra_map_ram #(
    parameter int DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire ridra_pkg::t_ram_req i_req,
    output logic                    o_rdata
);
    localparam int AW = $clog2(DEPTH);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ design/ridra_ctrl.sv @@
// Request sequencer: scans and updates the busy map, emits result beats.
`default_nettype none
`include "resource_id_range_allocator_macros.svh"
module ridra_ctrl #(
    parameter int CAPACITY = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_cap,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ridra_pkg::t_req     i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ridra_pkg::t_res          o_out_data,
    output ridra_pkg::t_ram_req      o_ram,
    input  wire logic                i_rdata
);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]      r_state, n_state, r_after, n_after;
    logic [CW-1:0]   r_ra, n_ra, r_lim, n_lim, r_did, n_did, r_rs, n_rs, r_wa, n_wa;
    logic            r_dv, n_dv, r_inrun, n_inrun, r_wval, n_wval, r_op, n_op;
    logic            r_consec, n_consec, r_ov;
    logic [7:0]      r_rl, n_rl, r_left, n_left, r_count, n_count, r_used, n_used;
    logic [7:0]      r_wn, n_wn;
    ridra_pkg::t_res r_pend, n_pend, r_out, out_beat;
    ridra_pkg::t_ram_req ram;

    logic [7:0]    free_ids, run_len, rel_end;
    logic [CW-1:0] run_st;
    logic          scan_end, emit_go;

    assign free_ids = (i_cap > r_used) ? 8'(i_cap - r_used) : 8'd0;
    assign run_len  = r_inrun ? 8'(r_rl + 8'd1) : 8'd1;
    assign run_st   = r_inrun ? r_rs : r_did;
    assign scan_end = !r_dv && (r_ra >= r_lim);
    assign rel_end  = 8'({1'b0, i_in_data.start_id} + i_in_data.count);
    assign emit_go  = (r_state == S_EMIT) && (!r_ov || i_out_ready);

    always_comb begin
        n_state = r_state;  n_after = r_after;  n_ra = r_ra;  n_lim = r_lim;
        n_dv = 1'b0;  n_did = r_ra;  n_inrun = r_inrun;  n_rs = r_rs;  n_rl = r_rl;
        n_left = r_left;  n_count = r_count;  n_used = r_used;  n_wa = r_wa;
        n_wn = r_wn;  n_wval = r_wval;  n_pend = r_pend;  n_op = r_op;
        n_consec = r_consec;
        ram = '0;
        ram.raddr = 7'(r_ra);
        unique case (r_state)
            S_CLR: begin
                ram.we    = 1'b1;
                ram.waddr = 7'(r_wa);
                n_wa      = r_wa + CW'(1);
                if (r_wa == CW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.op;
                    n_consec = i_in_data.consecutive;
                    n_count  = i_in_data.count;
                    n_left   = i_in_data.count;
                    n_inrun  = 1'b0;
                    n_ra     = '0;
                    n_after  = S_IDLE;
                    n_pend   = '0;
                    n_pend.last = 1'b1;
                    if (i_in_data.count == 8'd0) begin
                        n_pend.status = ridra_pkg::ST_PARA;
                        n_state       = S_EMIT;
                    end else if (i_in_data.op == ridra_pkg::OP_ALLOC) begin
                        if (i_in_data.count > free_ids) begin
                            n_pend.status = ridra_pkg::ST_UNAVAIL;
                            n_state       = S_EMIT;
                        end else begin
                            n_lim   = CW'(i_cap);
                            n_state = S_SCAN;
                            if (!i_in_data.consecutive) begin
                                n_used = 8'(r_used + i_in_data.count);
                            end
                        end
                    end else begin
                        if (i_in_data.count > i_cap || rel_end > i_cap) begin
                            n_pend.status = ridra_pkg::ST_PARA;
                            n_state       = S_EMIT;
                        end else begin
                            n_ra    = CW'(i_in_data.start_id);
                            n_rs    = CW'(i_in_data.start_id);
                            n_lim   = CW'(rel_end);
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (r_op == ridra_pkg::OP_RELEASE) begin
                        // any free ID in the range rejects the release
                        if (!i_rdata) begin
                            n_pend.status = ridra_pkg::ST_PARA;
                            n_after       = S_IDLE;
                            n_state       = S_EMIT;
                        end
                    end else if (r_consec) begin
                        if (!i_rdata) begin
                            n_inrun = 1'b1;
                            n_rs    = run_st;
                            n_rl    = run_len;
                            if (run_len >= r_count) begin
                                n_wa    = run_st;
                                n_wn    = r_count;
                                n_wval  = 1'b1;
                                n_used  = 8'(r_used + r_count);
                                n_state = S_WR;
                            end
                        end else begin
                            n_inrun = 1'b0;
                        end
                    end else begin
                        if (!i_rdata) begin
                            ram.we    = 1'b1;
                            ram.waddr = 7'(r_did);
                            ram.wdata = 1'b1;
                            n_inrun   = 1'b1;
                            n_rs      = run_st;
                            n_rl      = run_len;
                            n_left    = r_left - 8'd1;
                            if (r_left == 8'd1) begin
                                n_pend.status      = ridra_pkg::ST_OK;
                                n_pend.piece_start = 7'(run_st);
                                n_pend.piece_count = run_len;
                                n_pend.last        = 1'b1;
                                n_after            = S_IDLE;
                                n_state            = S_EMIT;
                            end
                        end else if (r_inrun) begin
                            n_pend.status      = ridra_pkg::ST_OK;
                            n_pend.piece_start = 7'(r_rs);
                            n_pend.piece_count = r_rl;
                            n_pend.last        = 1'b0;
                            n_inrun            = 1'b0;
                            n_ra               = r_did + CW'(1);
                            n_after            = S_SCAN;
                            n_state            = S_EMIT;
                        end
                    end
                end else if (scan_end) begin
                    n_after = S_IDLE;
                    if (r_op == ridra_pkg::OP_RELEASE) begin
                        n_wa    = r_rs;
                        n_wn    = r_count;
                        n_wval  = 1'b0;
                        n_used  = (r_used >= r_count) ? 8'(r_used - r_count) : 8'd0;
                        n_state = S_WR;
                    end else if (r_consec || !r_inrun) begin
                        n_pend.status = ridra_pkg::ST_UNAVAIL;
                        n_state       = S_EMIT;
                    end else begin
                        n_pend.status      = ridra_pkg::ST_OK;
                        n_pend.piece_start = 7'(r_rs);
                        n_pend.piece_count = r_rl;
                        n_pend.last        = 1'b1;
                        n_state            = S_EMIT;
                    end
                end
                // advance the read pointer while the scan continues
                if (n_state == S_SCAN && r_ra < r_lim) begin
                    n_dv = 1'b1;
                    n_ra = r_ra + CW'(1);
                end
            end
            S_WR: begin
                ram.we    = 1'b1;
                ram.waddr = 7'(r_wa);
                ram.wdata = r_wval;
                n_wa      = r_wa + CW'(1);
                n_wn      = r_wn - 8'd1;
                if (r_wn == 8'd1) begin
                    n_pend.status      = ridra_pkg::ST_OK;
                    n_pend.piece_start = (r_op == ridra_pkg::OP_RELEASE) ? 7'd0 : 7'(r_rs);
                    n_pend.piece_count = (r_op == ridra_pkg::OP_RELEASE) ? 8'd0 : r_count;
                    n_pend.last        = 1'b1;
                    n_after            = S_IDLE;
                    n_state            = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stamp the free count onto the pending beat as it moves to the output
    always_comb begin
        out_beat            = r_pend;
        out_beat.free_count = free_ids;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_wa    <= '0;
            r_used  <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wa    <= n_wa;
            r_used  <= n_used;
            r_dv    <= n_dv;
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_after  <= n_after;   r_ra    <= n_ra;    r_lim   <= n_lim;
        r_did    <= n_did;     r_inrun <= n_inrun; r_rs    <= n_rs;
        r_rl     <= n_rl;      r_left  <= n_left;  r_count <= n_count;
        r_wn     <= n_wn;      r_wval  <= n_wval;  r_pend  <= n_pend;
        r_op     <= n_op;      r_consec <= n_consec;
        if (emit_go) begin
            r_out <= out_beat;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_ram       = ram;

    `RIDRA_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= 8'(CAPACITY))
    `RIDRA_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !ram.we)
    `RIDRA_ASSERT_NXT(a_wr_to_emit, i_clk, i_rst_n, r_state == S_WR && r_wn == 8'd1,
        r_state == S_EMIT)
    `RIDRA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN && r_dv,
        r_did < r_lim)
endmodule
`default_nettype wire

@@ design/resource_id_range_allocator.sv @@
// Top level of the first-fit ID range allocator.
// Allocate scans the busy map from ID 0 up to the capacity and stops early once satisfied;
//   a contiguous run is then marked in a write pass; a scattered allocate marks IDs as it scans
//   and emits a beat per piece. Release makes one check pass and one clear pass over the range.
// One request at a time; the busy map scan reads one ID per cycle, pausing to emit a piece.
// Reset: synchronous, active low; a clearing pass then zeroes every busy map entry,
//   during which no request is taken. Capacity resets to CAPACITY, the in-use count to zero.
`default_nettype none
module resource_id_range_allocator #(
    parameter int CAPACITY = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ridra_pkg::t_req i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ridra_pkg::t_res      o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [7:0]      i_cfg_data
);
    // Capacity register: take every write beat, saturate at the pool size.
    logic [7:0] r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 8'(CAPACITY);
        end else if (i_cfg_valid) begin
            r_cap <= (i_cfg_data > 8'(CAPACITY)) ? 8'(CAPACITY) : i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Busy map lives in a single memory; the sequencer owns both its ports.
    ridra_pkg::t_ram_req ram_req;
    logic                ram_rdata;

    ridra_map_ram #(
        .DEPTH(CAPACITY)
    ) u_map (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rdata(ram_rdata)
    );

    // Sequencer: check, scan and mark, then hand result beats to the output register.
    ridra_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (r_cap),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .o_ram      (ram_req),
        .i_rdata    (ram_rdata)
    );
endmodule
`default_nettype wire
